/* sv/lcdm_pkg.sv */
package lcdm_pkg;

  // widths fixed by the word formats
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 11;
  localparam int COUNT_W    = 23;
  localparam int DIM_W      = 13;   // holds any clamped frame size up to 4096
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [COUNT_W-1:0] HIT_MAX = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_END      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_FIRST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_END      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY  = 3'd6;

  // register reset values
  localparam logic [11:0]        RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0]        RST_FRAME_HEIGHT = 12'd480;
  localparam logic [COORD_W-1:0] RST_ROW_FIRST    = 11'd2;
  localparam logic [COORD_W-1:0] RST_ROW_END      = 11'd477;
  localparam logic [COORD_W-1:0] RST_COL_FIRST    = 11'd2;
  localparam logic [COORD_W-1:0] RST_COL_END      = 11'd637;
  localparam logic [PIX_W-1:0]   RST_SENSITIVITY  = 8'd25;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             start_of_frame;
  } lcdm_in_t;

  typedef struct packed {
    logic               in_region;
    logic               damaged;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
    logic [COUNT_W-1:0] damage_count;
    logic               frame_done;
  } lcdm_out_t;

  // per-pixel control that rides down the pipe
  typedef struct packed {
    logic               region;
    logic [COORD_W-1:0] crow;
    logic [COORD_W-1:0] ccol;
    logic               done;
    logic               clr;
  } lcdm_ctl_t;

endpackage

/* sv/lcdm_in_if.sv */
interface lcdm_in_if import lcdm_pkg::*; ();
  logic     valid;
  logic     ready;
  lcdm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/lcdm_out_if.sv */
interface lcdm_out_if import lcdm_pkg::*; ();
  logic      valid;
  logic      ready;
  lcdm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/lcdm_ram.sv */
module lcdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/local_contrast_damage_mask.sv */
// Local contrast damage mask. Takes RGB pixels in raster order, one word
// per clock unless stalled, forms V = max(R,G,B) and decides center (r,c)
// when pixel (r+RADIUS, c+RADIUS) arrives: a center inside the configured
// region is damaged if any neighbour in the (2*RADIUS+1)^2 square differs
// from it by more than the sensitivity. Every input word yields exactly one
// result word, carrying the running per-frame damage count (saturating at
// 2^23-1). Throughput is one pixel per clock while the output is not
// stalled; the line store is one dual-port RAM (one read, one write per
// cycle) holding, per column, the last 2*RADIUS lines packed in one word,
// so each pixel costs exactly one read and one write. The line store is
// read at the edge that accepts a word, the window shifts when stage 1
// moves on, and compare plus count land in the output register when stage
// 2 moves on. The output register lets the next pixel be accepted while a
// result waits. The line store needs no clearing pass: unwritten rows and
// columns are masked by position. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module local_contrast_damage_mask import lcdm_pkg::*; #(
  parameter int RADIUS     = 2,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lcdm_in_if.sink               in_word,
  lcdm_out_if.source            out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WIN    = 2 * RADIUS + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LINE_W = 2 * RADIUS * PIX_W;   // packed column of older lines

  // ---------------- configuration registers ----------------
  logic [11:0]        cfg_fw_r, cfg_fh_r;
  logic [COORD_W-1:0] row_first_r, row_end_r, col_first_r, col_end_r;
  logic [PIX_W-1:0]   sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fw_r    <= RST_FRAME_WIDTH;
      cfg_fh_r    <= RST_FRAME_HEIGHT;
      row_first_r <= RST_ROW_FIRST;
      row_end_r   <= RST_ROW_END;
      col_first_r <= RST_COL_FIRST;
      col_end_r   <= RST_COL_END;
      sens_r      <= RST_SENSITIVITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_fw_r    <= cfg_data;
        CFG_FRAME_HEIGHT: cfg_fh_r    <= cfg_data;
        CFG_ROW_FIRST:    row_first_r <= cfg_data[COORD_W-1:0];
        CFG_ROW_END:      row_end_r   <= cfg_data[COORD_W-1:0];
        CFG_COL_FIRST:    col_first_r <= cfg_data[COORD_W-1:0];
        CFG_COL_END:      col_end_r   <= cfg_data[COORD_W-1:0];
        CFG_SENSITIVITY:  sens_r      <= cfg_data[PIX_W-1:0];
        default: ;                    // unused index, write dropped
      endcase
    end
  end

  // frame size clamped to [1, MAX]
  logic [DIM_W-1:0] fw, fh;

  always_comb begin
    if (cfg_fw_r == '0) begin
      fw = DIM_W'(1);
    end else if (DIM_W'(cfg_fw_r) > DIM_W'(MAX_WIDTH)) begin
      fw = DIM_W'(MAX_WIDTH);
    end else begin
      fw = DIM_W'(cfg_fw_r);
    end
    if (cfg_fh_r == '0) begin
      fh = DIM_W'(1);
    end else if (DIM_W'(cfg_fh_r) > DIM_W'(MAX_HEIGHT)) begin
      fh = DIM_W'(MAX_HEIGHT);
    end else begin
      fh = DIM_W'(cfg_fh_r);
    end
  end

  // ---------------- pipeline handshake ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_go, s2_go, s1_free, s2_free, accept;

  assign s2_go   = s2_v_r && (!out_v_r || out_word.ready);
  assign s2_free = !s2_v_r || s2_go;
  assign s1_go   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_go;
  assign accept  = in_word.valid && s1_free;

  assign in_word.ready = s1_free;

  // ---------------- stage 0: position, region, V ----------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] pc0;
  logic [ROW_W-1:0] pr0;
  logic [PIX_W-1:0] v0;
  logic [DIM_W-1:0] cr_ext, cc_ext;
  logic [WIN-1:0]   row_ok0, col_ok0;
  lcdm_ctl_t        ctl0;

  always_comb begin
    v0 = in_word.data.red;
    if (in_word.data.green > v0) v0 = in_word.data.green;
    if (in_word.data.blue > v0)  v0 = in_word.data.blue;

    pr0 = in_word.data.start_of_frame ? '0 : row_r;
    pc0 = in_word.data.start_of_frame ? '0 : col_r;
    // a geometry change may leave the counters outside the frame
    if (DIM_W'(pr0) >= fh) pr0 = '0;
    if (DIM_W'(pc0) >= fw) pc0 = '0;

    if (DIM_W'(pc0) + DIM_W'(1) >= fw) begin
      col_nxt = '0;
      row_nxt = (DIM_W'(pr0) + DIM_W'(1) >= fh) ? '0 : pr0 + ROW_W'(1);
    end else begin
      col_nxt = pc0 + COL_W'(1);
      row_nxt = pr0;
    end

    // window row k is frame row pr0-2R+k, column j is pc0-2R+j
    for (int k = 0; k < WIN; k++) begin
      row_ok0[k] = (DIM_W'(pr0) + DIM_W'(k)) >= DIM_W'(2 * RADIUS);
      col_ok0[k] = (DIM_W'(pc0) + DIM_W'(k)) >= DIM_W'(2 * RADIUS);
    end

    cr_ext = DIM_W'(pr0) - DIM_W'(RADIUS);
    cc_ext = DIM_W'(pc0) - DIM_W'(RADIUS);

    ctl0.region = (DIM_W'(pr0) >= DIM_W'(RADIUS)) && (DIM_W'(pc0) >= DIM_W'(RADIUS))
               && (cr_ext >= DIM_W'(row_first_r)) && (cr_ext < DIM_W'(row_end_r))
               && (cc_ext >= DIM_W'(col_first_r)) && (cc_ext < DIM_W'(col_end_r));
    ctl0.crow = ctl0.region ? cr_ext[COORD_W-1:0] : '0;
    ctl0.ccol = ctl0.region ? cc_ext[COORD_W-1:0] : '0;
    ctl0.done = (DIM_W'(pr0) == fh - DIM_W'(1)) && (DIM_W'(pc0) == fw - DIM_W'(1));
    ctl0.clr  = (pr0 == '0) && (pc0 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------- line store ----------------
  logic [LINE_W-1:0] ram_rdata, ram_wdata;
  logic [COL_W-1:0]  s1_pc_r;

  lcdm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_pc_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (pc0),
    .rdata (ram_rdata)
  );

  // ---------------- stage 1: column assembly, write-back ----------------
  logic [PIX_W-1:0]  s1_v8_r;
  logic [WIN-1:0]    s1_row_ok_r, s1_col_ok_r;
  lcdm_ctl_t         s1_ctl_r;
  logic              fwd_r;          // same column written as it was read
  logic [LINE_W-1:0] fwd_col_r;
  logic [LINE_W-1:0] col_word;
  logic [PIX_W-1:0]  col_vals [WIN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v8_r     <= v0;
      s1_pc_r     <= pc0;
      s1_row_ok_r <= row_ok0;
      s1_col_ok_r <= col_ok0;
      s1_ctl_r    <= ctl0;
      fwd_r       <= s1_go && (s1_pc_r == pc0);
      fwd_col_r   <= ram_wdata;
    end
  end

  always_comb begin
    col_word = fwd_r ? fwd_col_r : ram_rdata;
    for (int k = 0; k < WIN - 1; k++) begin
      col_vals[k] = col_word[k*PIX_W +: PIX_W];
    end
    col_vals[WIN-1] = s1_v8_r;
    // drop the oldest line, append this one
    for (int k = 0; k < WIN - 1; k++) begin
      ram_wdata[k*PIX_W +: PIX_W] = col_vals[k+1];
    end
  end

  // ---------------- stage 2: window compare, count ----------------
  logic [PIX_W-1:0]   window_r [WIN][WIN];   // [column][row]
  logic [WIN-1:0]     s2_row_ok_r, s2_col_ok_r;
  lcdm_ctl_t          s2_ctl_r;
  logic [COUNT_W-1:0] hit_r, cnt_base, cnt_nxt;
  logic [PIX_W-1:0]   center;
  logic [PIX_W-1:0]   nv, diff;
  logic               hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int j = 0; j < WIN - 1; j++) begin
        window_r[j] <= window_r[j+1];
      end
      window_r[WIN-1] <= col_vals;
      s2_row_ok_r     <= s1_row_ok_r;
      s2_col_ok_r     <= s1_col_ok_r;
      s2_ctl_r        <= s1_ctl_r;
    end
  end

  always_comb begin
    center = window_r[RADIUS][RADIUS];
    hit    = 1'b0;
    nv     = '0;
    diff   = '0;
    for (int j = 0; j < WIN; j++) begin
      for (int k = 0; k < WIN; k++) begin
        nv   = window_r[j][k];
        diff = (nv > center) ? nv - center : center - nv;
        if (s2_row_ok_r[k] && s2_col_ok_r[j] && (diff > sens_r)) hit = 1'b1;
      end
    end
    hit = hit && s2_ctl_r.region;

    cnt_base = s2_ctl_r.clr ? '0 : hit_r;
    cnt_nxt  = (hit && (cnt_base != HIT_MAX)) ? cnt_base + COUNT_W'(1) : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (s2_go) begin
      hit_r <= cnt_nxt;
    end
  end

  // ---------------- output register ----------------
  lcdm_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_word.ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r.in_region    <= s2_ctl_r.region;
      out_data_r.damaged      <= hit;
      out_data_r.center_row   <= s2_ctl_r.crow;
      out_data_r.center_col   <= s2_ctl_r.ccol;
      out_data_r.damage_count <= cnt_nxt;
      out_data_r.frame_done   <= s2_ctl_r.done;
    end
  end

  assign out_word.valid = out_v_r;
  assign out_word.data  = out_data_r;

  // ---------------- assertions ----------------
  // a stalled stage 1 must keep its column read intact (unwritten lines may be X)
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r && $stable(s1_pc_r) && (ram_rdata === $past(ram_rdata)))
    else $error("stage 1 lost its line store read while stalled");

  // position counter stays inside the frame after every pixel
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> DIM_W'(col_r) < $past(fw))
    else $error("column counter left the frame");

  // damage count only grows within a frame
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go && !s2_ctl_r.clr |=> hit_r >= $past(hit_r))
    else $error("damage count decreased inside a frame");

  // a region center always has its own row and column inside the frame
  a_center_ok: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_ctl_r.region |-> s2_row_ok_r[RADIUS] && s2_col_ok_r[RADIUS])
    else $error("region center masked out of its own window");

  // damage is only reported for a decided center
  a_dmg_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data_r.damaged |-> out_data_r.in_region)
    else $error("damage flagged outside the region");

endmodule

/* tb/lcdm_tb_pkg.sv */
`timescale 1ns / 100ps

package lcdm_tb_pkg;
  import lcdm_pkg::*;

  localparam int RAD      = 2;
  localparam int WIN_ROWS = 2 * RAD + 1;
  localparam int MAX_W    = 2048;
  localparam int MAX_H    = 2048;

  // Predicts the mask word of every accepted pixel and checks the block's words in order.
  class mask_checker;
    logic [PIX_W-1:0] v_lines [WIN_ROWS][MAX_W];
    int unsigned row_pos, col_pos, hits;
    int unsigned width_reg, height_reg, row_lo, row_hi, col_lo, col_hi, sens;
    lcdm_out_t   pending_masks[$];
    int unsigned mismatches;

    function new();
      foreach (v_lines[r, c]) v_lines[r][c] = '0;
      row_pos    = 0;
      col_pos    = 0;
      hits       = 0;
      width_reg  = 32'(RST_FRAME_WIDTH);
      height_reg = 32'(RST_FRAME_HEIGHT);
      row_lo     = 32'(RST_ROW_FIRST);
      row_hi     = 32'(RST_ROW_END);
      col_lo     = 32'(RST_COL_FIRST);
      col_hi     = 32'(RST_COL_END);
      sens       = 32'(RST_SENSITIVITY);
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = val & 'hFFF;
        CFG_FRAME_HEIGHT: height_reg = val & 'hFFF;
        CFG_ROW_FIRST:    row_lo     = val & 'h7FF;
        CFG_ROW_END:      row_hi     = val & 'h7FF;
        CFG_COL_FIRST:    col_lo     = val & 'h7FF;
        CFG_COL_END:      col_hi     = val & 'h7FF;
        CFG_SENSITIVITY:  sens       = val & 'hFF;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(int unsigned val, int unsigned top);
      if (val == 0) return 1;
      if (val > top) return top;
      return val;
    endfunction

    function int unsigned pending();
      return pending_masks.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void take_pixel(lcdm_in_t px);
      int unsigned fw, fh, v, pr, pc, cr, cc, cv, nv, diff;
      int          nr, nc;
      bit          hit;
      lcdm_out_t   want;
      fw = clamp_size(width_reg, MAX_W);
      fh = clamp_size(height_reg, MAX_H);
      v  = 32'(px.red);
      if (32'(px.green) > v) v = 32'(px.green);
      if (32'(px.blue) > v) v = 32'(px.blue);
      if (px.start_of_frame) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (row_pos >= fh) row_pos = 0;
      if (col_pos >= fw) col_pos = 0;
      pr = row_pos;
      pc = col_pos;
      if (pr == 0 && pc == 0) hits = 0;
      v_lines[pr % WIN_ROWS][pc] = v[PIX_W-1:0];
      want = '0;
      if (pr >= RAD && pc >= RAD) begin
        cr = pr - RAD;
        cc = pc - RAD;
        if (cr >= row_lo && cr < row_hi && cc >= col_lo && cc < col_hi) begin
          cv  = 32'(v_lines[cr % WIN_ROWS][cc]);
          hit = 1'b0;
          // search stops at the first neighbor over the threshold
          for (nr = int'(cr) - RAD; nr <= int'(cr) + RAD && !hit; nr++) begin
            if (nr < 0) continue;
            for (nc = int'(cc) - RAD; nc <= int'(cc) + RAD && !hit; nc++) begin
              if (nc < 0 || nc >= int'(fw)) continue;
              nv   = 32'(v_lines[nr % WIN_ROWS][nc]);
              diff = (nv > cv) ? nv - cv : cv - nv;
              if (diff > sens) hit = 1'b1;
            end
          end
          if (hit && hits < HIT_MAX) hits++;
          want.in_region  = 1'b1;
          want.damaged    = hit;
          want.center_row = cr[COORD_W-1:0];
          want.center_col = cc[COORD_W-1:0];
        end
      end
      want.damage_count = hits[COUNT_W-1:0];
      want.frame_done   = (pr == fh - 1 && pc == fw - 1);
      if (pc + 1 >= fw) begin
        col_pos = 0;
        row_pos = (pr + 1 >= fh) ? 0 : pr + 1;
      end else begin
        col_pos = pc + 1;
      end
      pending_masks = {pending_masks, want};
    endfunction

    function void check_mask(lcdm_out_t got);
      lcdm_out_t want;
      if (pending_masks.size() == 0) begin
        flag($sformatf("result word with none expected: region=%0d dmg=%0d row=%0d col=%0d",
                       got.in_region, got.damaged, got.center_row, got.center_col));
        return;
      end
      want = pending_masks.pop_front();
      if (got.in_region !== want.in_region || got.damaged !== want.damaged ||
          got.center_row !== want.center_row || got.center_col !== want.center_col ||
          got.damage_count !== want.damage_count || got.frame_done !== want.frame_done)
        flag($sformatf({"expected region=%0d dmg=%0d row=%0d col=%0d count=%0d done=%0d, ",
                        "got region=%0d dmg=%0d row=%0d col=%0d count=%0d done=%0d"},
                       want.in_region, want.damaged, want.center_row, want.center_col,
                       want.damage_count, want.frame_done,
                       got.in_region, got.damaged, got.center_row, got.center_col,
                       got.damage_count, got.frame_done));
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lcdm_pkg::*;
  import lcdm_tb_pkg::*;

  // hang guard: far above the slowest legal run (about 850 words, worst gaps and stalls)
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned RANDOM_WORDS = 550;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcdm_in_if  in_if ();
  lcdm_out_if out_if ();

  mask_checker mask_chk = new();

  bit          no_idle = 1'b0;   // quiet stretch: no gaps and no stalls
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  local_contrast_damage_mask u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_if),
    .out_word  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Region bound: the two extremes now and then, otherwise near the frame.
  function automatic int unsigned pick_bound(input int unsigned span);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 2047;
      default: return $urandom_range(0, span + 1);
    endcase
  endfunction

  // Pixel mostly near a drifting brightness level, sometimes fully random.
  function automatic lcdm_in_t make_pixel(input logic sof, input int unsigned level);
    lcdm_in_t    px;
    int unsigned v;
    if ($urandom_range(0, 9) < 7) begin
      v = level + $urandom_range(0, 12);
      if (v > 255) v = 255;
      px.red   = 8'($urandom_range(0, v));
      px.green = 8'($urandom_range(0, v));
      px.blue  = 8'($urandom_range(0, v));
      case ($urandom_range(0, 2))
        0:       px.red   = 8'(v);
        1:       px.green = 8'(v);
        default: px.blue  = 8'(v);
      endcase
    end else begin
      px.red   = 8'($urandom);
      px.green = 8'($urandom);
      px.blue  = 8'($urandom);
    end
    px.start_of_frame = sof;
    return px;
  endfunction

  // Sink side: ready drops for random stretches.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Result monitor: every accepted word goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) mask_chk.check_mask(out_if.data);
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[local_contrast_damage_mask] ERROR");
      $finish;
    end
  end

  // One register write; called at a clock edge, returns at a clock edge.
  // The extra edge keeps we from being lowered and raised in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    mask_chk.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_region(input int unsigned fw, input int unsigned fh,
                            input int unsigned rf, input int unsigned re,
                            input int unsigned cf, input int unsigned ce,
                            input int unsigned sens);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_ROW_FIRST, rf);
    write_reg(CFG_ROW_END, re);
    write_reg(CFG_COL_FIRST, cf);
    write_reg(CFG_COL_END, ce);
    write_reg(CFG_SENSITIVITY, sens);
  endtask

  // Offers one pixel word after a random gap and holds it until taken.
  task automatic send_pixel(input lcdm_in_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= px;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    mask_chk.take_pixel(px);
  endtask

  // Sender holds off until every expected word is back, then lets the
  // three-stage pipe settle so a register write finds the block idle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (mask_chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A run of pixels that starts a new frame; frames wrap on their own after
  // that, with a stray start-of-frame now and then to break one early.
  task automatic run_pixels(input int unsigned count, input bit hold_mid);
    int unsigned level;
    logic        sof;
    level = $urandom_range(0, 255);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) level = $urandom_range(0, 255);
      sof = (i == 0) || ($urandom_range(0, 299) == 0);
      if (hold_mid && i == count / 2) wait_idle();
      send_pixel(make_pixel(sof, level));
    end
  endtask

  initial begin
    lcdm_in_t    px;
    int unsigned random_sent;
    int unsigned fw, fh, rows, cols, sens, count, phase;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_FRAME_WIDTH;
    cfg_data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame, 5x5, whole frame in region. Only a 0 against a 255
    // beats sensitivity 254, so some centers are damaged and some not.
    // Top row carries the channel extremes; center (2,2) is black.
    set_region(5, 5, 0, 2047, 0, 2047, 254);
    for (int i = 0; i < 25; i++) begin
      px = '{red: 8'h55, green: 8'hAA, blue: 8'h80, start_of_frame: 1'b0};
      case (i)
        0:  px = '{red: 8'hFF, green: 8'h00, blue: 8'h00, start_of_frame: 1'b1};
        1:  px = '{red: 8'h00, green: 8'hFF, blue: 8'h00, start_of_frame: 1'b0};
        2:  px = '{red: 8'h00, green: 8'h00, blue: 8'hFF, start_of_frame: 1'b0};
        3:  px = '{red: 8'h00, green: 8'h00, blue: 8'h00, start_of_frame: 1'b0};
        4:  px = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, start_of_frame: 1'b0};
        12: px = '{red: 8'h00, green: 8'h00, blue: 8'h00, start_of_frame: 1'b0};
        default: ;
      endcase
      send_pixel(px);
    end
    wait_idle();

    // Random phases on small frames: sizes of 0 (taken as 1) up to a dozen,
    // empty, partial and full regions, sensitivity extremes. Each phase
    // covers one to three frames so the position wraps and the count restarts.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 11))
        0:       fw = 0;
        1:       fw = 1;
        2:       fw = 3;
        default: fw = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 11))
        0:       fh = 0;
        1:       fh = 1;
        2:       fh = 3;
        default: fh = $urandom_range(2, 9);
      endcase
      case ($urandom_range(0, 5))
        0:       sens = 0;
        1:       sens = 255;
        2, 3:    sens = $urandom_range(4, 40);
        default: sens = $urandom_range(0, 255);
      endcase
      set_region(fw, fh, pick_bound(fh), pick_bound(fh), pick_bound(fw), pick_bound(fw), sens);
      cols  = (fw == 0) ? 1 : fw;
      rows  = (fh == 0) ? 1 : fh;
      count = cols * rows * $urandom_range(1, 3) + $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 4) == 0);
      run_pixels(count, phase == 2);
      wait_idle();
      random_sent += count;
      phase++;
    end
    no_idle = 1'b0;

    // Wide frame: width written past the maximum is taken as 2048; a short
    // run along part of the first line.
    set_region(4095, 3, 0, 2047, 0, 2047, $urandom_range(10, 40));
    run_pixels(100, 1'b0);
    wait_idle();

    // Tall frame: height past the maximum, three columns, a few dozen lines.
    set_region(3, 4095, 1, 2047, 0, 2047, $urandom_range(10, 40));
    run_pixels(100, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mask_chk.mismatches == 0 && mask_chk.pending() == 0) begin
      $display("[local_contrast_damage_mask] OK");
    end else begin
      $display("[local_contrast_damage_mask] ERROR");
    end
    $finish;
  end

endmodule
